// ----- hdl/spbi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spbi_pkg: shared definitions of the sorted palette builder and indexer
// Table geometry, operation and result codes, the colour key function and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package spbi_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 25;

    // Pixel normalization.
    localparam logic [7:0]       ALPHA_LIMIT     = 8'h7F;
    localparam logic [KEY_W-1:0] TRANSPARENT_KEY = '1;

    // Operation codes of a request.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_MAP    = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic shift_start;
        logic shift_step;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic searching;
        logic range_empty;
        logic found;
        logic need_shift;
        logic shift_last;
        logic out_free;
    } t_dp_stat;

    // A transparent pixel collapses to all ones; otherwise alpha becomes 0.
    function automatic logic [KEY_W-1:0] make_key(input logic [7:0] alpha,
                                                  input logic [7:0] red,
                                                  input logic [7:0] green,
                                                  input logic [7:0] blue);
        logic [KEY_W-1:0] key;
        if (alpha > ALPHA_LIMIT) begin
            key = TRANSPARENT_KEY;
        end else begin
            key = {1'b0, red, green, blue};
        end
        return key;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/spbi_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spbi_dp: datapath of the sorted palette builder and indexer
// Holds the sorted colour table memory, the binary search bounds, the entry
// count, the sticky overflow flag and the result output register.
// ----------------------------------------------------------------------------
module spbi_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire spbi_pkg::t_dp_cmd  i_cmd,
    output spbi_pkg::t_dp_stat      o_stat,
    input  wire logic [1:0]         i_operation,
    input  wire logic [7:0]         i_pixel_alpha,
    input  wire logic [7:0]         i_pixel_red,
    input  wire logic [7:0]         i_pixel_green,
    input  wire logic [7:0]         i_pixel_blue,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output logic [2:0]              o_status,
    output logic [7:0]              o_palette_index,
    output logic [8:0]              o_entries_used,
    output logic                    o_overflowed
);
    import spbi_pkg::*;

    // Colour table and its registered read data.
    logic [KEY_W-1:0] mem [TABLE_DEPTH];
    logic [KEY_W-1:0] r_rdata;

    // Request and search registers.
    logic [1:0]       r_op;
    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_lo;
    logic [CNT_W-1:0] r_hi;
    logic [IDX_W-1:0] r_mid;
    logic             r_found;
    logic [IDX_W-1:0] r_sp;

    // Table state.
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;

    // Result register.
    logic             r_out_valid;
    logic [2:0]       r_res_status;
    logic [7:0]       r_res_index;
    logic [8:0]       r_res_used;
    logic             r_res_ovf;

    // Next values and decoded conditions.
    logic [CNT_W-1:0] n_lo;
    logic [CNT_W-1:0] n_hi;
    logic [CNT_W-1:0] n_mid;
    logic [CNT_W-1:0] n_count;
    logic             n_ovf;
    logic             w_is_insert;
    logic             w_is_map;
    logic             w_full;
    logic             w_insert_new;
    logic [IDX_W-1:0] w_pos;
    logic [2:0]       w_status;
    logic [IDX_W-1:0] w_index;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_data;

    // Operation decode and table conditions.
    assign w_is_insert  = (r_op == OP_INSERT);
    assign w_is_map     = (r_op == OP_MAP);
    assign w_full       = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_pos        = r_found ? r_mid : r_lo[IDX_W-1:0];
    assign w_insert_new = w_is_insert && !r_found && !w_full;

    // One binary search step: narrow the range around the probed entry.
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (r_key < r_rdata) begin
            n_hi = CNT_W'(r_mid);
        end else begin
            n_lo = CNT_W'(r_mid) + CNT_W'(1);
        end
        n_mid = n_lo + ((n_hi - n_lo) >> 1);
    end

    // Result code, index and committed table state of the finished request.
    always_comb begin
        w_status = ST_NOT_FOUND;
        w_index  = '0;
        n_count  = r_count;
        n_ovf    = r_ovf;
        if (r_op == OP_CLEAR) begin
            w_status = ST_CLEARED;
            n_count  = '0;
            n_ovf    = 1'b0;
        end else if (w_is_insert) begin
            if (r_found) begin
                w_status = ST_FOUND;
                w_index  = w_pos;
            end else if (w_full) begin
                w_status = ST_OVERFLOW;
                n_ovf    = 1'b1;
            end else begin
                w_status = ST_INSERTED;
                w_index  = w_pos;
                n_count  = r_count + CNT_W'(1);
            end
        end else if (w_is_map && r_found) begin
            w_status = ST_FOUND;
            w_index  = w_pos;
        end
    end

    // Read port: first probe, later probes, and the upward shift sweep.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_mid;
        if (i_cmd.load) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(r_count >> 1);
        end else if (i_cmd.step) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(n_mid);
        end else if (i_cmd.shift_start) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(r_count - CNT_W'(1));
        end else if (i_cmd.shift_step) begin
            rd_en   = 1'b1;
            rd_addr = r_sp - IDX_W'(2);
        end
    end

    // Write port: moved entries during the sweep, the new key at the end.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_sp;
        wr_data = r_rdata;
        if (i_cmd.shift_step) begin
            wr_en = 1'b1;
        end else if (i_cmd.finish && w_insert_new) begin
            wr_en   = 1'b1;
            wr_addr = w_pos;
            wr_data = r_key;
        end
    end

    // Table memory.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Control state: counts, flags and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (i_cmd.step && (r_key == r_rdata)) begin
                r_found <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_ovf       <= n_ovf;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload, search bounds and shift pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_key <= make_key(i_pixel_alpha, i_pixel_red, i_pixel_green, i_pixel_blue);
            r_lo  <= '0;
            r_hi  <= r_count;
            r_mid <= IDX_W'(r_count >> 1);
        end else if (i_cmd.step && (r_key != r_rdata)) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= IDX_W'(n_mid);
        end
        if (i_cmd.shift_start) begin
            r_sp <= IDX_W'(r_count);
        end else if (i_cmd.shift_step) begin
            r_sp <= r_sp - IDX_W'(1);
        end
        if (i_cmd.finish) begin
            r_res_status <= w_status;
            r_res_index  <= 8'(w_index);
            r_res_used   <= 9'(n_count);
            r_res_ovf    <= n_ovf;
        end
    end

    // Status toward the controller.
    assign o_stat.searching   = w_is_insert || w_is_map;
    assign o_stat.range_empty = (r_lo >= r_hi);
    assign o_stat.found       = r_found;
    assign o_stat.need_shift  = w_insert_new && (r_count != CNT_W'(w_pos));
    assign o_stat.shift_last  = (r_sp == w_pos + IDX_W'(1));
    assign o_stat.out_free    = !r_out_valid || !i_out_stall;

    // Result outputs.
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_res_status;
    assign o_palette_index = r_res_index;
    assign o_entries_used  = r_res_used;
    assign o_overflowed    = r_res_ovf;

endmodule
`default_nettype wire

// ----- hdl/spbi_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spbi_ctrl: controller of the sorted palette builder and indexer
// Sequences one request through search, the insert shift sweep and the
// result handoff, one request at a time.
// ----------------------------------------------------------------------------
module spbi_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire spbi_pkg::t_dp_stat i_stat,
    output spbi_pkg::t_dp_cmd       o_cmd
);
    import spbi_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SRCH   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SRCH;
                end
            end
            S_SRCH: begin
                if (!i_stat.searching || i_stat.range_empty || i_stat.found) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DECIDE: begin
                if (i_stat.need_shift) begin
                    o_cmd.shift_start = 1'b1;
                    n_state           = S_SHIFT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.shift_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A new request is taken only between requests.
    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ----- hdl/sorted_palette_builder_indexer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_palette_builder_indexer_top: exact palette builder and pixel indexer
// Keeps a sorted table of normalized colours, inserts new colours in order
// and maps pixels to their table index.
// ----------------------------------------------------------------------------
// Each request is handled alone, start to finish. An insert or a map runs a
// binary search that probes one table entry a cycle through the table
// memory's single read port. The result of every request, a clear as well,
// is presented in the same cycle that the block becomes free. An insert of a
// new colour moves every entry that sits above the insertion point up by
// one, one entry per cycle, through the memory's one read and one write
// port. The result sits in an output register, so a request can be accepted
// while the previous result still waits; the next result is held back until
// that one is taken. The table needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module sorted_palette_builder_indexer_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_operation,
    input  wire logic [7:0] i_pixel_alpha,
    input  wire logic [7:0] i_pixel_red,
    input  wire logic [7:0] i_pixel_green,
    input  wire logic [7:0] i_pixel_blue,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [2:0]      o_status,
    output logic [7:0]      o_palette_index,
    output logic [8:0]      o_entries_used,
    output logic            o_overflowed
);
    import spbi_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Request sequencing.
    spbi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Table, search and result datapath.
    spbi_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_operation     (i_operation),
        .i_pixel_alpha   (i_pixel_alpha),
        .i_pixel_red     (i_pixel_red),
        .i_pixel_green   (i_pixel_green),
        .i_pixel_blue    (i_pixel_blue),
        .i_out_stall     (i_stall),
        .o_out_valid     (o_valid),
        .o_status        (o_status),
        .o_palette_index (o_palette_index),
        .o_entries_used  (o_entries_used),
        .o_overflowed    (o_overflowed)
    );

endmodule
`default_nettype wire

// ----- tb/sv/palette_result_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palette_result_checker: result checker of the sorted palette builder
// Watches the request and result channels, keeps its own sorted colour table,
// works out the result of every accepted request and compares each accepted
// result, field by field, with the oldest result still owed.
// ----------------------------------------------------------------------------
module palette_result_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req_valid,
    input  wire logic       i_req_stall,
    input  wire logic [1:0] i_operation,
    input  wire logic [7:0] i_pixel_alpha,
    input  wire logic [7:0] i_pixel_red,
    input  wire logic [7:0] i_pixel_green,
    input  wire logic [7:0] i_pixel_blue,
    input  wire logic       i_rsp_valid,
    input  wire logic       i_rsp_stall,
    input  wire logic [2:0] i_status,
    input  wire logic [7:0] i_palette_index,
    input  wire logic [8:0] i_entries_used,
    input  wire logic       i_overflowed,
    output int              o_failures,
    output int              o_pending
);
    import spbi_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] index;
        logic [8:0] entries;
        logic       overflowed;
    } t_palette_result;

    // Shadow copy of the colour table, kept sorted in ascending key order.
    logic [KEY_W-1:0] shadow_palette [TABLE_DEPTH];
    int               shadow_fill;
    logic             shadow_overflow;

    // Results owed by the block, oldest first.
    t_palette_result  owed_results [$];

    initial begin
        o_failures = 0;
        o_pending  = 0;
    end

    // Applies one request to the shadow table and returns the result it owes.
    function automatic t_palette_result apply_palette_request(
        input logic [1:0] op,
        input logic [7:0] alpha,
        input logic [7:0] red,
        input logic [7:0] green,
        input logic [7:0] blue
    );
        logic [KEY_W-1:0] key;
        int               lo;
        int               hi;
        int               mid;
        int               slot;
        bit               hit;
        t_palette_result  res;

        // Any alpha with its top bit set counts as fully transparent white.
        key = alpha[7] ? {KEY_W{1'b1}} : {1'b0, red, green, blue};

        // Binary search over the used part of the table.
        lo  = 0;
        hi  = shadow_fill;
        hit = 1'b0;
        while (lo < hi && !hit) begin
            mid = lo + (hi - lo) / 2;
            if (key < shadow_palette[mid]) begin
                hi = mid;
            end else if (key > shadow_palette[mid]) begin
                lo = mid + 1;
            end else begin
                hit = 1'b1;
                lo  = mid;
            end
        end
        slot = lo;

        res.status = ST_NOT_FOUND;
        res.index  = '0;
        case (op)
            OP_CLEAR: begin
                shadow_fill     = 0;
                shadow_overflow = 1'b0;
                res.status      = ST_CLEARED;
            end
            OP_INSERT: begin
                if (hit) begin
                    res.status = ST_FOUND;
                    res.index  = slot[7:0];
                end else if (shadow_fill >= TABLE_DEPTH) begin
                    shadow_overflow = 1'b1;
                    res.status      = ST_OVERFLOW;
                end else begin
                    for (int i = shadow_fill; i > slot; i--) begin
                        shadow_palette[i] = shadow_palette[i-1];
                    end
                    shadow_palette[slot] = key;
                    shadow_fill++;
                    res.status = ST_INSERTED;
                    res.index  = slot[7:0];
                end
            end
            OP_MAP: begin
                if (hit) begin
                    res.status = ST_FOUND;
                    res.index  = slot[7:0];
                end
            end
            default: begin
            end
        endcase
        res.entries    = shadow_fill[8:0];
        res.overflowed = shadow_overflow;
        return res;
    endfunction

    // Counts a failure and reports only the first few of them.
    task automatic note_failure(input string msg);
        o_failures++;
        if (o_failures <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Compare accepted results first, then queue the result of an accepted request.
    always @(posedge i_clk) begin : watch_channels
        t_palette_result got;
        t_palette_result want;
        if (!i_rst_n) begin
            shadow_fill     = 0;
            shadow_overflow = 1'b0;
            owed_results.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                got = '{i_status, i_palette_index, i_entries_used, i_overflowed};
                if (owed_results.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected result: status %0d index %0d entries %0d overflow %0b",
                        got.status, got.index, got.entries, got.overflowed));
                end else begin
                    want = owed_results.pop_front();
                    if (got.status !== want.status || got.index !== want.index ||
                        got.entries !== want.entries ||
                        got.overflowed !== want.overflowed) begin
                        note_failure($sformatf({"result mismatch: expected status %0d ",
                            "index %0d entries %0d overflow %0b, got status %0d ",
                            "index %0d entries %0d overflow %0b"},
                            want.status, want.index, want.entries, want.overflowed,
                            got.status, got.index, got.entries, got.overflowed));
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                owed_results.push_back(apply_palette_request(i_operation, i_pixel_alpha,
                    i_pixel_red, i_pixel_green, i_pixel_blue));
            end
        end
        o_pending = owed_results.size();
    end

endmodule
`default_nettype wire

// ----- tb/sv/sorted_palette_builder_indexer_top_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_palette_builder_indexer_top_tb: testbench of the palette builder
// Drives a short directed run over the normalization and search corners, then
// random episodes of inserts and lookups, some of which fill the table until
// it overflows. Both channels idle at random but in the last phase; a
// separate checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module sorted_palette_builder_indexer_top_tb;
    import spbi_pkg::*;

    localparam logic [1:0] OP_RESERVED  = 2'd3;
    localparam int         ITEM_TARGET  = 1900;
    localparam int         PHASE_ITEMS  = 640;
    localparam int         FILL_ITEMS   = 300;
    localparam int         DRAIN_CYCLES = 300;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic       o_stall;
    logic [1:0] i_operation   = OP_CLEAR;
    logic [7:0] i_pixel_alpha = '0;
    logic [7:0] i_pixel_red   = '0;
    logic [7:0] i_pixel_green = '0;
    logic [7:0] i_pixel_blue  = '0;
    logic       o_valid;
    logic       i_stall       = 1'b0;
    logic [2:0] o_status;
    logic [7:0] o_palette_index;
    logic [8:0] o_entries_used;
    logic       o_overflowed;

    int         failures;
    int         pending;
    int         issued            = 0;
    int         sender_idle_pct   = 0;
    int         receiver_idle_pct = 0;
    logic [31:0] inserted_pixels [$];

    sorted_palette_builder_indexer_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_pixel_alpha  (i_pixel_alpha),
        .i_pixel_red    (i_pixel_red),
        .i_pixel_green  (i_pixel_green),
        .i_pixel_blue   (i_pixel_blue),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_palette_index(o_palette_index),
        .o_entries_used (o_entries_used),
        .o_overflowed   (o_overflowed)
    );

    palette_result_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_stall    (o_stall),
        .i_operation    (i_operation),
        .i_pixel_alpha  (i_pixel_alpha),
        .i_pixel_red    (i_pixel_red),
        .i_pixel_green  (i_pixel_green),
        .i_pixel_blue   (i_pixel_blue),
        .i_rsp_valid    (o_valid),
        .i_rsp_stall    (i_stall),
        .i_status       (o_status),
        .i_palette_index(o_palette_index),
        .i_entries_used (o_entries_used),
        .i_overflowed   (o_overflowed),
        .o_failures     (failures),
        .o_pending      (pending)
    );

    always #1 i_clk = ~i_clk;

    // The result side stalls at random, at the rate of the current phase.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial begin
        #(6_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    // Sends one request, with random gaps, and returns at the accepting edge.
    task automatic send_request(input logic [1:0] op, input logic [31:0] pixel);
        if (issued < PHASE_ITEMS) begin
            sender_idle_pct   = 36;
            receiver_idle_pct = 56;
        end else if (issued < 2 * PHASE_ITEMS) begin
            sender_idle_pct   = 56;
            receiver_idle_pct = 36;
        end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
        end
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_pixel_alpha <= pixel[31:24];
        i_pixel_red   <= pixel[23:16];
        i_pixel_green <= pixel[15:8];
        i_pixel_blue  <= pixel[7:0];
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        issued++;
    endtask

    function automatic logic [31:0] random_opaque_pixel();
        return {8'($urandom_range(127)), 24'($urandom)};
    endfunction

    function automatic logic [31:0] random_transparent_pixel();
        return {8'($urandom_range(255, 128)), 24'($urandom)};
    endfunction

    // Same normalized colour as a previous pixel, with a fresh alpha of the same
    // class; every transparent pixel is one colour whatever its red, green, blue.
    function automatic logic [31:0] same_colour_as(input logic [31:0] pixel);
        if (pixel[31]) begin
            return random_transparent_pixel();
        end
        return {8'($urandom_range(127)), pixel[23:0]};
    endfunction

    initial begin : stimulus
        logic [1:0]  op;
        logic [31:0] pixel;
        int          episode;
        int          length;
        int          roll;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: alpha threshold, ordering at both ends, duplicates,
        // lookups of absent colours, the reserved operation and clearing.
        send_request(OP_MAP,      32'h00_00_00_00);
        send_request(OP_INSERT,   32'h00_00_00_00);
        send_request(OP_INSERT,   32'h7F_FF_FF_FF);
        send_request(OP_INSERT,   32'h80_12_34_56);
        send_request(OP_INSERT,   32'hFF_00_00_00);
        send_request(OP_INSERT,   32'h00_80_80_80);
        send_request(OP_INSERT,   32'h55_80_80_80);
        send_request(OP_MAP,      32'hAA_01_02_03);
        send_request(OP_MAP,      32'h00_FF_FF_FF);
        send_request(OP_MAP,      32'h7F_01_01_01);
        send_request(OP_RESERVED, 32'hFF_FF_FF_FF);
        send_request(OP_INSERT,   32'h00_00_00_01);
        send_request(OP_INSERT,   32'h00_FF_00_00);
        send_request(OP_MAP,      32'h7F_00_00_01);
        send_request(OP_CLEAR,    32'hFF_FF_FF_FF);
        send_request(OP_MAP,      32'h00_00_00_00);
        send_request(OP_INSERT,   32'h55_AA_55_AA);
        send_request(OP_RESERVED, 32'h00_00_00_00);
        send_request(OP_MAP,      32'h00_55_AA_55);
        send_request(OP_CLEAR,    32'h00_00_00_00);

        // Random episodes; every fifth one fills the table past its depth.
        episode = 0;
        while (issued < ITEM_TARGET) begin
            if (episode % 5 == 1 || $urandom_range(99) < 85) begin
                send_request(OP_CLEAR, $urandom);
                inserted_pixels.delete();
            end
            if (episode % 5 == 1) begin
                for (int n = 0; n < FILL_ITEMS && issued < ITEM_TARGET; n++) begin
                    if ($urandom_range(9) == 0 && inserted_pixels.size() > 0) begin
                        pixel = same_colour_as(
                            inserted_pixels[$urandom_range(inserted_pixels.size() - 1)]);
                        send_request(($urandom_range(1) == 0) ? OP_MAP : OP_INSERT, pixel);
                    end else begin
                        pixel = random_opaque_pixel();
                        send_request(OP_INSERT, pixel);
                        inserted_pixels.push_back(pixel);
                    end
                end
            end else begin
                length = $urandom_range(60, 5);
                for (int n = 0; n < length && issued < ITEM_TARGET; n++) begin
                    roll = $urandom_range(99);
                    if (roll < 4) begin
                        op = OP_CLEAR;
                    end else if (roll < 8) begin
                        op = OP_RESERVED;
                    end else if (roll < 55) begin
                        op = OP_INSERT;
                    end else begin
                        op = OP_MAP;
                    end
                    roll = $urandom_range(99);
                    if (roll < 50 && inserted_pixels.size() > 0) begin
                        pixel = same_colour_as(
                            inserted_pixels[$urandom_range(inserted_pixels.size() - 1)]);
                    end else if (roll < 90) begin
                        pixel = random_opaque_pixel();
                    end else begin
                        pixel = random_transparent_pixel();
                    end
                    send_request(op, pixel);
                    if (op == OP_INSERT) begin
                        inserted_pixels.push_back(pixel);
                    end else if (op == OP_CLEAR) begin
                        inserted_pixels.delete();
                    end
                end
            end
            episode++;
        end

        @(negedge i_clk);
        i_valid <= 1'b0;

        // Let every owed result arrive, then watch for stray ones.
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (failures == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
hdl/spbi_pkg.sv
hdl/spbi_dp.sv
hdl/spbi_ctrl.sv
hdl/sorted_palette_builder_indexer_top.sv
tb/sv/palette_result_checker.sv
tb/sv/sorted_palette_builder_indexer_top_tb.sv
